/* hw/rtl/lmtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_pkg: shared types and constants of the match tuple decoder
// Field widths, the length and offset biases, the decode phases and the result item layout.
// ----------------------------------------------------------------------------
package lmtd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 8;
   localparam int OFS_W    = 17;
   localparam int COUNT_W  = 15;
   localparam int REPHI_W  = 7;

   localparam logic [LEN_W-1:0] LEN_BIAS = 8'd4;
   localparam logic [OFS_W-1:0] OFS_BIAS = 17'd4;

   // decode phase, one-hot
   typedef enum logic [5:0] {
      PH_MARKER     = 6'b000001,
      PH_SHORT_OFS  = 6'b000010,
      PH_LONG_LO    = 6'b000100,
      PH_LONG_HI    = 6'b001000,
      PH_REP_FIRST  = 6'b010000,
      PH_REP_SECOND = 6'b100000
   } phase_type;

   typedef struct packed {
      logic                long_form;
      logic [LEN_W-1:0]    match_length;
      logic [OFS_W-1:0]    match_offset;
      logic [COUNT_W-1:0]  repeat_count;
   } result_type;

endpackage

/* hw/rtl/lmtd_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_in_reg: input byte register
// Holds one incoming item until the decode stage consumes it.
// ----------------------------------------------------------------------------
module lmtd_in_reg
   import lmtd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              step,
   output logic              byte_valid,
   output logic [BYTE_W-1:0] byte_data
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              take;

   assign req_ready = !valid_ff || step;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !step);
   assign data_in   = take ? req_data_byte : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

/* hw/rtl/lmtd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_core: tuple decode state and step logic
// Advances the phase on each consumed byte and flags a finished tuple.
// ----------------------------------------------------------------------------
module lmtd_core
   import lmtd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   output logic              res_valid,
   output result_type        res
);

   phase_type            phase_ff, phase_in;
   logic                 form_ff, form_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [OFS_W-1:0]     ofs_ff, ofs_in;
   logic [LEN_W-1:0]     prevl_ff, prevl_in;
   logic [OFS_W-1:0]     prevo_ff, prevo_in;
   logic [REPHI_W-1:0]   rephi_ff, rephi_in;
   logic                 tuple_end, rep_end;
   logic [COUNT_W-1:0]   count;

   always_comb begin
      phase_in  = phase_ff;
      form_in   = form_ff;
      len_in    = len_ff;
      ofs_in    = ofs_ff;
      prevl_in  = prevl_ff;
      prevo_in  = prevo_ff;
      rephi_in  = rephi_ff;
      tuple_end = 1'b0;
      rep_end   = 1'b0;
      res_valid = 1'b0;
      count     = COUNT_W'(1);
      if (step) begin
         case (phase_ff)
            PH_SHORT_OFS: begin
               ofs_in    = ofs_ff + {{(OFS_W-BYTE_W){1'b0}}, data_byte} + OFS_BIAS;
               tuple_end = 1'b1;
            end
            PH_LONG_LO: begin
               ofs_in   = {{(OFS_W-BYTE_W){1'b0}}, data_byte};
               phase_in = PH_LONG_HI;
            end
            PH_LONG_HI: begin
               ofs_in    = {1'b0, data_byte, ofs_ff[BYTE_W-1:0]} + OFS_BIAS;
               tuple_end = 1'b1;
            end
            PH_REP_FIRST: begin
               if (data_byte[BYTE_W-1]) begin
                  rephi_in = data_byte[REPHI_W-1:0];
                  phase_in = PH_REP_SECOND;
               end else begin
                  rep_end = 1'b1;
                  count   = {{(COUNT_W-BYTE_W){1'b0}}, data_byte};
               end
            end
            PH_REP_SECOND: begin
               rep_end = 1'b1;
               count   = {rephi_ff, data_byte};
            end
            default: begin
               // marker byte: top bit picks the form
               form_in = data_byte[7];
               if (!data_byte[7]) begin
                  ofs_in   = {6'd0, data_byte[2:0], 8'd0};
                  len_in   = {4'd0, data_byte[6:3]} + LEN_BIAS;
                  phase_in = PH_SHORT_OFS;
               end else begin
                  ofs_in   = '0;
                  len_in   = {1'b0, data_byte[6:0]} + LEN_BIAS;
                  phase_in = PH_LONG_LO;
               end
            end
         endcase

         if (tuple_end) begin
            if (len_ff == prevl_ff && ofs_in == prevo_ff) begin
               phase_in = PH_REP_FIRST;
            end else begin
               prevl_in  = len_ff;
               prevo_in  = ofs_in;
               phase_in  = PH_MARKER;
               res_valid = 1'b1;
            end
         end
         if (rep_end) begin
            prevl_in  = '0;
            prevo_in  = '0;
            phase_in  = PH_MARKER;
            res_valid = 1'b1;
         end
      end
   end

   assign res.long_form    = form_ff;
   assign res.match_length = len_ff;
   assign res.match_offset = ofs_in;
   assign res.repeat_count = count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MARKER;
         prevl_ff <= '0;
         prevo_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         prevl_ff <= prevl_in;
         prevo_ff <= prevo_in;
      end
      form_ff  <= form_in;
      len_ff   <= len_in;
      ofs_ff   <= ofs_in;
      rephi_ff <= rephi_in;
   end

endmodule

/* hw/rtl/lmtd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_out_reg: result register
// Holds a finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module lmtd_out_reg
   import lmtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        res_valid,
   input  result_type  res,
   output logic        can_take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp
);

   logic        valid_ff, valid_in;
   result_type  data_ff, data_in;

   assign can_take = !valid_ff || rsp_ready;
   assign valid_in = res_valid || (valid_ff && !rsp_ready);
   assign data_in  = res_valid ? res : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

/* hw/rtl/lz_match_tuple_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_match_tuple_decoder: back-reference tuple decoder
// Decodes short and long match tuples with optional repeat counts.
// ----------------------------------------------------------------------------
// The block takes one byte of the tuple stream per item and returns one result
// item per complete tuple: the form, the length and offset (each with a bias of
// 4 added) and a repeat count. A tuple that repeats the previous tuple's length
// and offset is followed by one or two count bytes, and its result appears only
// after the last count byte; otherwise the count is 1. The block accepts one
// byte every cycle unless the output stalls: the decode step works on the byte
// held in the input register, and a finished result lands in the output register
// at the next edge, so a result passes through both registers after its last
// byte is taken. A stalled output holds the decode step, and ready drops while
// the input register holds a byte. No configuration; reset returns the decoder
// to expect a marker byte and clears the stored previous tuple.
// ----------------------------------------------------------------------------
module lz_match_tuple_decoder
   import lmtd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_long_form,
   output logic [LEN_W-1:0]    rsp_match_length,
   output logic [OFS_W-1:0]    rsp_match_offset,
   output logic [COUNT_W-1:0]  rsp_repeat_count
);

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              can_take;
   logic              step;
   logic              res_valid;
   result_type        res;
   result_type        rsp;

   // advance decode only when the output register has room
   assign step = byte_valid && can_take;

   lmtd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .step          (step),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data)
   );

   lmtd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   lmtd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_long_form    = rsp.long_form;
   assign rsp_match_length = rsp.match_length;
   assign rsp_match_offset = rsp.match_offset;
   assign rsp_repeat_count = rsp.repeat_count;

endmodule

/* tb/lmtd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_checker: result predictor and comparator for the match tuple decoder
// Watches both channels, decodes every accepted byte into expected tuples and
// compares each accepted result item with the oldest expected one.
// ----------------------------------------------------------------------------
module lmtd_checker
   import lmtd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_long_form,
   input  logic [LEN_W-1:0]    rsp_match_length,
   input  logic [OFS_W-1:0]    rsp_match_offset,
   input  logic [COUNT_W-1:0]  rsp_repeat_count,
   output int                  fail_count,
   output int                  pending
);

   phase_type            phase;
   logic                 form_bit;
   logic [LEN_W-1:0]     length_hold;
   logic [OFS_W-1:0]     offset_hold;
   logic [LEN_W-1:0]     prev_length;
   logic [OFS_W-1:0]     prev_offset;
   logic [REPHI_W-1:0]   repeat_high;

   result_type           expected_tuples[$];
   result_type           oldest;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_fault(input string msg);
      $display("[%0t] decoder mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic queue_tuple(input logic [COUNT_W-1:0] count);
      expected_tuples.push_back(result_type'{form_bit, length_hold, offset_hold, count});
   endtask

   // A tuple equal to the stored one waits for its count bytes.
   task automatic close_tuple();
      if (length_hold == prev_length && offset_hold == prev_offset) begin
         phase = PH_REP_FIRST;
      end else begin
         prev_length = length_hold;
         prev_offset = offset_hold;
         phase       = PH_MARKER;
         queue_tuple(COUNT_W'(1));
      end
   endtask

   task automatic close_repeat(input logic [COUNT_W-1:0] count);
      prev_length = '0;
      prev_offset = '0;
      phase       = PH_MARKER;
      queue_tuple(count);
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      case (phase)
         PH_SHORT_OFS: begin
            offset_hold = offset_hold + OFS_W'(b) + OFS_BIAS;
            close_tuple();
         end
         PH_LONG_LO: begin
            offset_hold = OFS_W'(b);
            phase       = PH_LONG_HI;
         end
         PH_LONG_HI: begin
            offset_hold = offset_hold + OFS_W'({b, 8'd0}) + OFS_BIAS;
            close_tuple();
         end
         PH_REP_FIRST: begin
            if (b[7]) begin
               repeat_high = b[6:0];
               phase       = PH_REP_SECOND;
            end else begin
               close_repeat({7'd0, b});
            end
         end
         PH_REP_SECOND: begin
            close_repeat({repeat_high, b});
         end
         default: begin
            // marker byte; top bit selects the form
            form_bit = b[7];
            if (!b[7]) begin
               offset_hold = OFS_W'({b[2:0], 8'd0});
               length_hold = LEN_W'(b[6:3]) + LEN_BIAS;
               phase       = PH_SHORT_OFS;
            end else begin
               offset_hold = '0;
               length_hold = LEN_W'(b[6:0]) + LEN_BIAS;
               phase       = PH_LONG_LO;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase       = PH_MARKER;
         form_bit    = 1'b0;
         length_hold = '0;
         offset_hold = '0;
         prev_length = '0;
         prev_offset = '0;
         repeat_high = '0;
         expected_tuples.delete();
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_tuples.size() == 0) begin
               report_fault($sformatf("result item with none expected (len %0d ofs %0d)",
                                      rsp_match_length, rsp_match_offset));
            end else begin
               oldest = expected_tuples.pop_front();
               if (rsp_long_form !== oldest.long_form)
                  report_fault($sformatf("long_form got %0b want %0b",
                                         rsp_long_form, oldest.long_form));
               if (rsp_match_length !== oldest.match_length)
                  report_fault($sformatf("match_length got %0d want %0d",
                                         rsp_match_length, oldest.match_length));
               if (rsp_match_offset !== oldest.match_offset)
                  report_fault($sformatf("match_offset got %0d want %0d",
                                         rsp_match_offset, oldest.match_offset));
               if (rsp_repeat_count !== oldest.repeat_count)
                  report_fault($sformatf("repeat_count got %0d want %0d",
                                         rsp_repeat_count, oldest.repeat_count));
            end
         end
      end
      pending = expected_tuples.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the match tuple decoder
// Feeds directed and random tuple streams with random gaps and stalls, lets
// the checker predict and compare, and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
   import lmtd_pkg::*;

   localparam int TARGET_BYTES = 400;
   localparam int LONG_HOLD    = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_long_form;
   logic [LEN_W-1:0]    rsp_match_length;
   logic [OFS_W-1:0]    rsp_match_offset;
   logic [COUNT_W-1:0]  rsp_repeat_count;

   int  fail_count;
   int  pending;
   int  cycle_count = 0;
   int  bytes_sent = 0;

   // biased length and offset of the last new tuple sent; 0 after a repeat
   int  last_len = 0;
   int  last_ofs = 0;

   // shared with the result sink: random gaps on/off, one long hold-off
   bit  gaps_enabled = 1'b0;
   bit  sink_hold_req = 1'b0;

   lz_match_tuple_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_long_form    (rsp_long_form),
      .rsp_match_length (rsp_match_length),
      .rsp_match_offset (rsp_match_offset),
      .rsp_repeat_count (rsp_repeat_count)
   );

   lmtd_checker decode_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_long_form    (rsp_long_form),
      .rsp_match_length (rsp_match_length),
      .rsp_match_offset (rsp_match_offset),
      .rsp_repeat_count (rsp_repeat_count),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if the decoder hangs or results go missing.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result sink: random stall bursts, plus one long hold-off on request so
   // the decoder backs up and drops req_ready.
   initial begin : sink_loop
      @(posedge clock);
      forever begin
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Mostly random, with the field extremes favored.
   function automatic int pick_field(input int hi);
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return 0;
      if (sel == 1)
         return hi;
      return $urandom_range(0, hi);
   endfunction

   // Offer one byte and hold it until the decoder takes it. Called at a
   // rising edge; returns at the edge where the item was accepted, so a
   // following byte goes out back-to-back without dropping valid.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Encode one tuple from its raw fields. When it equals the last new tuple,
   // append the count bytes (cnt in one byte, or two when two_byte is set).
   task automatic send_tuple(input bit long_f, input int len_f, input int ofs_f,
                             input int cnt, input bit two_byte);
      logic [6:0]  len_bits;
      logic [15:0] ofs_bits;
      logic [14:0] cnt_bits;
      len_bits = len_f[6:0];
      ofs_bits = ofs_f[15:0];
      cnt_bits = cnt[14:0];
      if (long_f) begin
         send_byte({1'b1, len_bits});
         send_byte(ofs_bits[7:0]);
         send_byte(ofs_bits[15:8]);
      end else begin
         send_byte({1'b0, len_bits[3:0], ofs_bits[10:8]});
         send_byte(ofs_bits[7:0]);
      end
      if (len_f + 4 == last_len && ofs_f + 4 == last_ofs) begin
         if (two_byte) begin
            send_byte({1'b1, cnt_bits[14:8]});
            send_byte(cnt_bits[7:0]);
         end else begin
            send_byte({1'b0, cnt_bits[6:0]});
         end
         last_len = 0;
         last_ofs = 0;
      end else begin
         last_len = len_f + 4;
         last_ofs = ofs_f + 4;
      end
   endtask

   // When the last tuple sent was new, a third of the tuples repeat it, in either
   // form where the values fit the short form; the rest carry random fields.
   task automatic send_random_tuple();
      bit long_f;
      int len_f;
      int ofs_f;
      int cnt;
      bit two_byte;
      if (last_len != 0 && $urandom_range(0, 2) == 0) begin
         len_f  = last_len - 4;
         ofs_f  = last_ofs - 4;
         long_f = (len_f > 15 || ofs_f > 2047) ? 1'b1 : 1'($urandom_range(0, 1));
      end else begin
         long_f = 1'($urandom_range(0, 1));
         len_f  = pick_field(long_f ? 127 : 15);
         ofs_f  = pick_field(long_f ? 65535 : 2047);
      end
      cnt      = $urandom_range(0, 1) ? pick_field(127) : pick_field(32767);
      two_byte = (cnt > 127) ? 1'b1 : 1'($urandom_range(0, 1));
      send_tuple(long_f, len_f, ofs_f, cnt, two_byte);
   endtask

   // Hold off until every expected result item has come back. Sample at the
   // falling edge, after the checker has settled, then realign to a rising one.
   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      bit hold_done;
      bit drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes of both forms, one- and two-byte counts.
      // Fresh previous (all zero) never matches the first tuple.
      send_tuple(1'b0, 0, 0, 0, 1'b0);
      // same tuple again: single count byte of zero passes through as 0
      send_tuple(1'b0, 0, 0, 0, 1'b0);
      send_tuple(1'b0, 15, 2047, 0, 1'b0);
      // long form equal to the short one above: repeat, largest count
      send_tuple(1'b1, 15, 2047, 32767, 1'b1);
      // previous was cleared, so this is new
      send_tuple(1'b1, 127, 65535, 0, 1'b0);
      send_tuple(1'b1, 127, 65535, 127, 1'b0);
      send_tuple(1'b1, 0, 0, 0, 1'b0);
      // short repeat of a long tuple, two-byte count of zero
      send_tuple(1'b0, 0, 0, 0, 1'b1);

      // Random stream with gaps on both sides, a long sink hold-off, a full
      // drain pause, and gap-free stretches including the tail.
      gaps_enabled = 1'b1;
      while (bytes_sent < TARGET_BYTES) begin
         if (!hold_done && bytes_sent >= 110) begin
            // keep offering bytes back-to-back while the sink holds off
            gaps_enabled  = 1'b0;
            sink_hold_req = 1'b1;
            repeat (24) send_random_tuple();
            hold_done = 1'b1;
         end
         if (!drain_done && bytes_sent >= 200) begin
            req_valid <= 1'b0;
            wait_drained();
            drain_done = 1'b1;
         end
         gaps_enabled = (bytes_sent < 200) || (bytes_sent >= 260 && bytes_sent < 330);
         send_random_tuple();
      end

      req_valid    <= 1'b0;
      gaps_enabled  = 1'b0;
      wait_drained();
      // let any stray result item show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lmtd_pkg.sv
hw/rtl/lmtd_in_reg.sv
hw/rtl/lmtd_core.sv
hw/rtl/lmtd_out_reg.sv
hw/rtl/lz_match_tuple_decoder.sv
tb/lmtd_checker.sv
tb/tb.sv
